/* rtl/fluted_column_height_map_top_defines.svh */
// Assertion macros shared by the height map RTL.
`ifndef FLUTED_COLUMN_HEIGHT_MAP_TOP_DEFINES_SVH
`define FLUTED_COLUMN_HEIGHT_MAP_TOP_DEFINES_SVH
`ifndef SYNTH
`define FCM_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcm assertion failed");
`define FCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcm assertion failed");
`else
`define FCM_ASSERT_IMPLIES(lbl, ante, cons)
`define FCM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/fcm_pkg.sv */
package fcm_pkg;

  localparam int Q_W    = 17;
  localparam int RAD_W  = 33;
  localparam int ROOT_W = 17;
  localparam int RAMP_W = 11;

  typedef logic [Q_W-1:0] q_t;

  localparam q_t ONE = 17'h10000;
  localparam q_t OUT_MAX = 17'h1FFFF;
  localparam logic [17:0] THREE_ONE = 18'h30000;

  localparam int SCALE_SH = 27;
  localparam logic [63:0] SCALE_RECIP = ((64'd1 << SCALE_SH) + 64'd32) / 64'd33;
  localparam logic [27:0] SCALE_MUL = 28'(64'd38 * SCALE_RECIP);

  localparam logic [7:0]  RIDGES = 8'd200;
  localparam logic [15:0] BAND_LO = 16'd63570;
  localparam logic [15:0] BAND_HI = 16'd64880;
  localparam logic [19:0] CAP_BASE = 20'd720896;
  localparam int CAP_SH = 23;
  localparam logic [19:0] CAP_RECIP = 20'(((64'd1 << CAP_SH) + 64'd9) / 64'd10);

  localparam logic [15:0] TOP_A = 16'd61604;
  localparam logic [15:0] TOP_B = 16'd62915;
  localparam logic [15:0] BOT_A = 16'd655;
  localparam logic [15:0] BOT_B = 16'd1311;
  localparam logic [63:0] TOP_SPAN = 64'd1311;
  localparam logic [63:0] BOT_SPAN = 64'd656;
  localparam int TOP_SH = 22;
  localparam int BOT_SH = 21;
  localparam logic [27:0] TOP_RECIP =
    28'(((64'd1 << (TOP_SH + 16)) + TOP_SPAN - 64'd1) / TOP_SPAN);
  localparam logic [27:0] BOT_RECIP =
    28'(((64'd1 << (BOT_SH + 16)) + BOT_SPAN - 64'd1) / BOT_SPAN);

  localparam logic [7:0] FLUTE_RESET = 8'd20;
  localparam logic REG_FLUTE_COUNT = 1'b0;

  localparam int FRONT_LAT  = 4;
  localparam int VCORE_LAT  = 4;
  localparam int VALIGN_LAT = FRONT_LAT + ROOT_W;
  localparam int VDELAY     = VALIGN_LAT - VCORE_LAT;

  typedef struct packed {
    logic             valid;
    logic [RAD_W-1:0] rad;
  } rad_item_t;

  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] root;
  } root_item_t;

  typedef struct packed {
    q_t cap;
    q_t st;
    q_t sb;
  } vside_t;

  typedef struct packed {
    logic valid;
    q_t   h;
  } height_item_t;

endpackage

/* rtl/fcm_front.sv */
module fcm_front
  import fcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [7:0]  flute_cnt,
  input  logic [15:0] u_frac,
  output rad_item_t   rad_o
);

  logic [FRONT_LAT-1:0] vld_r, vld_nxt;
  logic [23:0]          phase_prod;
  logic [15:0]          phase_r, phase_nxt;
  q_t                   twice, tri_val;
  logic [44:0]          scaled;
  logic [17:0]          x_wide;
  q_t                   x_r, x_nxt;
  logic [33:0]          x_sq;
  q_t                   xs_r, xs_nxt;
  logic [RAD_W-1:0]     rad_r, rad_nxt;

  always_comb begin
    phase_prod = flute_cnt * u_frac;
    phase_nxt  = phase_prod[15:0];
    twice      = {1'b0, phase_r[14:0], 1'b0};
    tri_val    = phase_r[15] ? twice : ONE - twice;
    scaled     = tri_val * SCALE_MUL;
    x_wide     = scaled[SCALE_SH+17:SCALE_SH];
    x_nxt      = (x_wide > 18'(ONE)) ? ONE : x_wide[Q_W-1:0];
    x_sq       = x_r * x_r;
    xs_nxt     = x_sq[32:16];
    rad_nxt    = {ONE - xs_r, 16'b0};
    vld_nxt    = {vld_r[FRONT_LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_r <= phase_nxt;
      x_r     <= x_nxt;
      xs_r    <= xs_nxt;
      rad_r   <= rad_nxt;
    end
  end

  assign rad_o.valid = vld_r[FRONT_LAT-1];
  assign rad_o.rad   = rad_r;

endmodule

/* rtl/fcm_sqrt.sv */
`include "fluted_column_height_map_top_defines.svh"

module fcm_sqrt
  import fcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  rad_item_t  rad_i,
  output root_item_t root_o
);

  localparam int TW = RAD_W + 2;

  logic [ROOT_W-1:0] vld_r, vld_nxt;
  logic [ROOT_W:0]   vld_s;
  logic [RAD_W-1:0]  rem_r    [ROOT_W];
  logic [RAD_W-1:0]  rem_nxt  [ROOT_W];
  logic [RAD_W-1:0]  rem_s    [ROOT_W+1];
  logic [ROOT_W-1:0] root_r   [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [ROOT_W-1:0] root_s   [ROOT_W+1];
  logic [TW-1:0]     trial    [ROOT_W];
  logic [ROOT_W-1:0] take;

  always_comb begin
    rem_s[0]  = rad_i.rad;
    root_s[0] = '0;
    vld_s[0]  = rad_i.valid;
    for (int k = 0; k < ROOT_W; k++) begin
      rem_s[k+1]  = rem_r[k];
      root_s[k+1] = root_r[k];
      vld_s[k+1]  = vld_r[k];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      trial[k] = (TW'(root_s[k]) << (ROOT_W - k)) + (TW'(1) << (2 * (ROOT_W - 1 - k)));
      take[k]  = TW'(rem_s[k]) >= trial[k];
      rem_nxt[k]  = take[k] ? rem_s[k] - trial[k][RAD_W-1:0] : rem_s[k];
      root_nxt[k] = take[k] ? root_s[k] | (ROOT_W'(1) << (ROOT_W - 1 - k)) : root_s[k];
      vld_nxt[k]  = vld_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root_o.valid = vld_r[ROOT_W-1];
  assign root_o.root  = root_r[ROOT_W-1];

  `FCM_ASSERT_IMPLIES(a_root_rem_bound, vld_r[ROOT_W-1], rem_r[ROOT_W-1] <= RAD_W'({root_r[ROOT_W-1], 1'b0}))

endmodule

/* rtl/fcm_vpath.sv */
module fcm_vpath
  import fcm_pkg::*;
#(
  parameter int V_W = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [V_W-1:0] v_i,
  output vside_t         vs_o
);

  logic [23:0]       prod200;
  logic              band_r, band_nxt;
  logic [15:0]       fr_r, fr_nxt;
  logic              tlo_r, tlo_nxt, thi_r, thi_nxt;
  logic              blo_r, blo_nxt, bhi_r, bhi_nxt;
  logic [RAMP_W-1:0] td_r, td_nxt, bd_r, bd_nxt;

  logic [19:0]       cap_num;
  logic [39:0]       cap_prod;
  logic [38:0]       tprod, bprod;
  q_t                cap2_r, cap2_nxt, st2_r, st2_nxt, sb2_r, sb2_nxt;

  logic [33:0]       tsq, bsq;
  logic [32:0]       tsq_r, bsq_r;
  q_t                cap3_r, st3_r, sb3_r;

  logic [17:0]       tw, bw;
  logic [50:0]       tpoly, bpoly;
  vside_t            core_r, core_nxt;
  vside_t            dly_r [VDELAY];

  always_comb begin
    band_nxt = (v_i >= V_W'(BAND_LO)) && (v_i <= V_W'(BAND_HI));
    prod200  = v_i[15:0] * RIDGES;
    fr_nxt   = prod200[15:0];
    tlo_nxt  = v_i <= V_W'(TOP_A);
    thi_nxt  = v_i >= V_W'(TOP_B);
    td_nxt   = RAMP_W'(v_i - V_W'(TOP_A));
    blo_nxt  = v_i <= V_W'(BOT_A);
    bhi_nxt  = v_i >= V_W'(BOT_B);
    bd_nxt   = RAMP_W'(v_i - V_W'(BOT_A));

    cap_num  = CAP_BASE - {3'b0, fr_r, 1'b0};
    cap_prod = cap_num * CAP_RECIP;
    cap2_nxt = band_r ? cap_prod[CAP_SH+Q_W-1:CAP_SH] : ONE;
    tprod    = td_r * TOP_RECIP;
    bprod    = bd_r * BOT_RECIP;
    st2_nxt  = tlo_r ? '0 : (thi_r ? ONE : tprod[TOP_SH+Q_W-1:TOP_SH]);
    sb2_nxt  = blo_r ? '0 : (bhi_r ? ONE : bprod[BOT_SH+Q_W-1:BOT_SH]);

    tsq = st2_r * st2_r;
    bsq = sb2_r * sb2_r;

    tw    = THREE_ONE - {st3_r, 1'b0};
    bw    = THREE_ONE - {sb3_r, 1'b0};
    tpoly = tsq_r * tw;
    bpoly = bsq_r * bw;
    core_nxt.cap = cap3_r;
    core_nxt.st  = tpoly[48:32];
    core_nxt.sb  = bpoly[48:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      band_r <= band_nxt;
      fr_r   <= fr_nxt;
      tlo_r  <= tlo_nxt;
      thi_r  <= thi_nxt;
      td_r   <= td_nxt;
      blo_r  <= blo_nxt;
      bhi_r  <= bhi_nxt;
      bd_r   <= bd_nxt;
      cap2_r <= cap2_nxt;
      st2_r  <= st2_nxt;
      sb2_r  <= sb2_nxt;
      tsq_r  <= tsq[32:0];
      bsq_r  <= bsq[32:0];
      cap3_r <= cap2_r;
      st3_r  <= st2_r;
      sb3_r  <= sb2_r;
      core_r <= core_nxt;
      dly_r[0] <= core_r;
      for (int i = 1; i < VDELAY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign vs_o = dly_r[VDELAY-1];

endmodule

/* rtl/fcm_blend.sv */
module fcm_blend
  import fcm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  root_item_t   root_i,
  input  vside_t       vs_i,
  output height_item_t h_o
);

  logic [2:0]  vld_r, vld_nxt;
  q_t          root_c;
  q_t          flute_r, flute_nxt;
  vside_t      vs1_r;
  logic [33:0] p_flute, p_cap;
  logic [34:0] inner_sum;
  q_t          inner_r, inner_nxt;
  q_t          sb2_r;
  logic [33:0] p_inner;
  logic [34:0] h_sum;
  logic [18:0] h_wide;
  q_t          h_r, h_nxt;

  always_comb begin
    root_c    = (root_i.root > ONE) ? ONE : root_i.root;
    flute_nxt = ONE - root_c;
    p_flute   = flute_r * (ONE - vs1_r.st);
    p_cap     = vs1_r.cap * vs1_r.st;
    inner_sum = 35'(p_flute) + 35'(p_cap);
    inner_nxt = inner_sum[32:16];
    p_inner   = inner_r * sb2_r;
    h_sum     = 35'({ONE - sb2_r, 16'b0}) + 35'(p_inner);
    h_wide    = h_sum[34:16];
    h_nxt     = (h_wide > 19'(OUT_MAX)) ? OUT_MAX : h_wide[Q_W-1:0];
    vld_nxt   = {vld_r[1:0], root_i.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flute_r <= flute_nxt;
      vs1_r   <= vs_i;
      inner_r <= inner_nxt;
      sb2_r   <= vs1_r.sb;
      h_r     <= h_nxt;
    end
  end

  assign h_o.valid = vld_r[2];
  assign h_o.h     = h_r;

endmodule

/* rtl/fluted_column_height_map_top.sv */
// Fluted column height map: one 17-bit Q1.16 surface height per (u, v) texel, accepted at
// one transaction per clock while in_ready is high, and registered at the output. The
// depth is set by the square root of the flute profile, which resolves one result bit per
// pipeline stage over 17 stages; the v side runs in parallel and is delayed to match. A
// stalled output keeps the pipeline full through an output register plus one skid entry.
// flute_count sits at byte address 0 of the configuration port, resets to 20, and may
// only be changed while no transaction is in flight.
`include "fluted_column_height_map_top_defines.svh"

module fluted_column_height_map_top
  import fcm_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_u_coord,
  input  logic [15:0] in_v_coord,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_surface_height,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NORM_W = (COORD_FRAC_BITS < 16) ? 32 - COORD_FRAC_BITS : 16;

  logic [NORM_W-1:0] u_q, v_q;
  logic [7:0]        flute_count_r;
  logic              cfg_wr;
  logic              pipe_en;
  logic              emit;
  logic              take;
  rad_item_t         rad_item;
  root_item_t        root_item;
  vside_t            vside;
  height_item_t      h_item;
  logic              out_valid_r, skid_valid_r;
  q_t                out_data_r, skid_data_r;

  if (COORD_FRAC_BITS >= 16) begin : g_shr
    assign u_q = NORM_W'(in_u_coord >> (COORD_FRAC_BITS - 16));
    assign v_q = NORM_W'(in_v_coord >> (COORD_FRAC_BITS - 16));
  end else begin : g_shl
    assign u_q = NORM_W'(in_u_coord) << (16 - COORD_FRAC_BITS);
    assign v_q = NORM_W'(in_v_coord) << (16 - COORD_FRAC_BITS);
  end

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_FLUTE_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == REG_FLUTE_COUNT) ? {24'b0, flute_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flute_count_r <= FLUTE_RESET;
    end else if (cfg_wr) begin
      flute_count_r <= cfg_pwdata[7:0];
    end
  end

  assign pipe_en  = !skid_valid_r;
  assign in_ready = pipe_en;

  fcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_valid),
    .flute_cnt (flute_count_r),
    .u_frac    (u_q[15:0]),
    .rad_o     (rad_item)
  );

  fcm_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .rad_i  (rad_item),
    .root_o (root_item)
  );

  fcm_vpath #(
    .V_W (NORM_W)
  ) u_vpath (
    .clk  (clk),
    .en   (pipe_en),
    .v_i  (v_q),
    .vs_o (vside)
  );

  fcm_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .root_i (root_item),
    .vs_i   (vside),
    .h_o    (h_item)
  );

  assign emit = h_item.valid && pipe_en;
  assign take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r  <= skid_valid_r || emit;
      skid_valid_r <= 1'b0;
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= skid_valid_r ? skid_data_r : h_item.h;
    end else if (emit) begin
      skid_data_r <= h_item.h;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_surface_height = out_data_r;

  `FCM_ASSERT_IMPLIES(a_skid_behind_out, skid_valid_r, out_valid_r)
  `FCM_ASSERT_NEXT(a_skid_fill, out_valid_r && !out_ready && emit, skid_valid_r)
  `FCM_ASSERT_NEXT(a_skid_drain, skid_valid_r && out_ready, !skid_valid_r && out_valid_r)

endmodule

/* test/fluted_column_height_map_top_tb.sv */
`timescale 1ns / 1ps

module fluted_column_height_map_top_tb;

  localparam int COORD_BITS = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 275;

  localparam logic [2:0] FLUTE_ADDR = 3'(4 * int'(fcm_pkg::REG_FLUTE_COUNT));
  localparam logic [2:0] UNUSED_ADDR = FLUTE_ADDR + 3'd4;

  localparam logic [63:0] UNIT = 64'd65536;
  localparam logic [63:0] HEIGHT_CAP = 64'd131071;
  localparam logic [63:0] RIDGE_COUNT = 64'd200;
  localparam logic [63:0] RIDGE_BASE = 64'd720896;
  localparam logic [63:0] BAND_START = 64'd63570;
  localparam logic [63:0] BAND_END = 64'd64880;
  localparam logic [63:0] CAPITAL_START = 64'd61604;
  localparam logic [63:0] CAPITAL_END = 64'd62915;
  localparam logic [63:0] BASE_START = 64'd655;
  localparam logic [63:0] BASE_END = 64'd1311;

  typedef struct {
    logic [15:0] u;
    logic [15:0] v;
  } texel_t;

  typedef struct {
    logic [15:0] u;
    logic [15:0] v;
    logic [16:0] height;
  } height_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_u_coord = '0;
  logic [15:0] in_v_coord = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] out_surface_height;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  texel_t  texel_q[$];
  height_t height_q[$];
  texel_t  next_texel;
  height_t oldest;
  logic [7:0] flute_setting = 8'd20;
  int mismatches = 0;
  int burst_left = 8;
  int gap_left = 0;
  int idle_cycles = 0;
  int ready_cycle = 0;
  int ready_mode = 0;
  int stall_left = 0;
  logic ready_next;

  fluted_column_height_map_top #(
    .COORD_FRAC_BITS(COORD_BITS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_u_coord        (in_u_coord),
    .in_v_coord        (in_v_coord),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_surface_height(out_surface_height),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem = n;
    root = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] hermite(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] v);
    logic [63:0] s;
    if (v <= a) begin
      s = '0;
    end else begin
      s = ((v - a) << 16) / (b - a);
      if (s > UNIT) s = UNIT;
    end
    return (s * s * (3 * UNIT - 2 * s)) >> 32;
  endfunction

  function automatic logic [63:0] mix(input logic [63:0] p, input logic [63:0] q,
                                      input logic [63:0] s);
    return (p * (UNIT - s) + q * s) >> 16;
  endfunction

  function automatic logic [16:0] predict_height(input logic [15:0] u, input logic [15:0] v,
                                                 input logic [7:0] flutes);
    logic [63:0] uq;
    logic [63:0] vq;
    logic [63:0] phase;
    logic [63:0] wave;
    logic [63:0] x;
    logic [63:0] xs;
    logic [63:0] root;
    logic [63:0] flute;
    logic [63:0] capital;
    logic [63:0] inner;
    logic [63:0] h;
    if (COORD_BITS >= 16) begin
      uq = 64'(u) >> (COORD_BITS - 16);
      vq = 64'(v) >> (COORD_BITS - 16);
    end else begin
      uq = 64'(u) << (16 - COORD_BITS);
      vq = 64'(v) << (16 - COORD_BITS);
    end
    phase = (64'(flutes) * uq) & 64'hFFFF;
    wave = (2 * phase >= UNIT) ? 2 * phase - UNIT : UNIT - 2 * phase;
    x = wave * 38 / 33;
    if (x > UNIT) x = UNIT;
    xs = (x * x) >> 16;
    root = int_sqrt((UNIT - xs) << 16);
    if (root > UNIT) root = UNIT;
    flute = UNIT - root;
    if (vq >= BAND_START && vq <= BAND_END) begin
      phase = (RIDGE_COUNT * vq) & 64'hFFFF;
      capital = (RIDGE_BASE - 2 * phase) / 10;
    end else begin
      capital = UNIT;
    end
    inner = mix(flute, capital, hermite(CAPITAL_START, CAPITAL_END, vq));
    h = mix(UNIT, inner, hermite(BASE_START, BASE_END, vq));
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    return h[16:0];
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic add_texel(input logic [15:0] u, input logic [15:0] v);
    texel_q.push_back('{u, v});
  endtask

  task automatic add_random_texels(input int count);
    logic [15:0] u;
    logic [15:0] v;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) v = 16'($urandom_range(61000, 65535));
      else if (pick == 3) v = 16'($urandom_range(0, 1500));
      else v = 16'($urandom);
      pick = $urandom_range(0, 19);
      if (pick == 0) u = 16'h0000;
      else if (pick == 1) u = 16'hFFFF;
      else u = 16'($urandom);
      add_texel(u, v);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (texel_q.size() != 0 || in_valid || height_q.size() != 0);
  endtask

  task automatic cfg_access(input logic write, input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    if (write && addr == FLUTE_ADDR) flute_setting = data[7:0];
    if (!write && cfg_prdata !== {24'd0, flute_setting})
      report($sformatf("flute_count read 0x%08h, expected 0x%08h", cfg_prdata,
                       {24'd0, flute_setting}));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        height_q.push_back('{in_u_coord, in_v_coord,
                             predict_height(in_u_coord, in_v_coord, flute_setting)});
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (texel_q.size() != 0) begin
        next_texel = texel_q.pop_front();
        in_u_coord <= next_texel.u;
        in_v_coord <= next_texel.v;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      ready_cycle <= ready_cycle + 1;
      if (ready_cycle % 200 == 199) ready_mode <= $urandom_range(0, 3);
      case (ready_mode)
        0: begin
          ready_next = 1'b1;
        end
        1: begin
          ready_next = 1'($urandom_range(0, 1));
        end
        2: begin
          ready_next = (ready_cycle % 5 == 0);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left = stall_left - 1;
            ready_next = 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 20);
            ready_next = 1'b0;
          end else begin
            ready_next = 1'b1;
          end
        end
      endcase
      out_ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (height_q.size() == 0) begin
        report($sformatf("surface_height 0x%05h arrived with no transaction pending",
                         out_surface_height));
      end else begin
        oldest = height_q.pop_front();
        if (out_surface_height !== oldest.height)
          report($sformatf("u=0x%04h v=0x%04h surface_height 0x%05h, expected 0x%05h",
                           oldest.u, oldest.v, out_surface_height, oldest.height));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] settings[6];
    settings = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd128,
                 8'($urandom_range(2, 254))};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    cfg_access(1'b0, FLUTE_ADDR, '0);

    add_texel(16'h0000, 16'h8000);
    add_texel(16'hFFFF, 16'h8000);
    add_texel(16'h8000, 16'h8000);
    add_texel(16'h0001, 16'h8000);
    add_texel(16'h0666, 16'h8000);
    add_texel(16'h0CCD, 16'h8000);
    add_texel(16'h1234, 16'h0000);
    add_texel(16'h1234, 16'hFFFF);
    add_texel(16'h1234, 16'd655);
    add_texel(16'h1234, 16'd656);
    add_texel(16'h1234, 16'd1000);
    add_texel(16'h1234, 16'd1311);
    add_texel(16'h1234, 16'd1312);
    add_texel(16'h1234, 16'd61604);
    add_texel(16'h1234, 16'd62000);
    add_texel(16'h1234, 16'd62915);
    add_texel(16'h1234, 16'd63569);
    add_texel(16'h1234, 16'd63570);
    add_texel(16'h1234, 16'd64200);
    add_texel(16'h1234, 16'd64880);
    add_texel(16'h1234, 16'd64881);
    add_random_texels(RANDOM_PER_PHASE);
    wait_drained();

    foreach (settings[i]) begin
      if (i == 2) cfg_access(1'b1, UNUSED_ADDR, 32'($urandom));
      cfg_access(1'b1, FLUTE_ADDR, {24'd0, settings[i]});
      cfg_access(1'b0, FLUTE_ADDR, '0);
      add_texel(16'h0000, 16'h4000);
      add_texel(16'hFFFF, 16'hFFFF);
      add_random_texels(RANDOM_PER_PHASE);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && height_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* fluted_column_height_map_top.f */
+incdir+rtl
rtl/fcm_pkg.sv
rtl/fcm_front.sv
rtl/fcm_sqrt.sv
rtl/fcm_vpath.sv
rtl/fcm_blend.sv
rtl/fluted_column_height_map_top.sv
test/fluted_column_height_map_top_tb.sv
